>>> rtl/shamh_pkg.sv
package shamh_pkg;

    localparam int LEN_BITS = 61;

    localparam logic [31:0] HASH_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    // schedule shift-in source
    localparam logic [2:0] SH_NONE = 3'd0;
    localparam logic [2:0] SH_DATA = 3'd1;
    localparam logic [2:0] SH_MARK = 3'd2;
    localparam logic [2:0] SH_ZERO = 3'd3;
    localparam logic [2:0] SH_LHI  = 3'd4;
    localparam logic [2:0] SH_LLO  = 3'd5;

    // result register load
    localparam logic [1:0] OUT_NONE   = 2'd0;
    localparam logic [1:0] OUT_DIGEST = 2'd1;
    localparam logic [1:0] OUT_ERROR  = 2'd2;

    typedef struct packed {
        logic [2:0] shift_sel;
        logic       count_add;
        logic       set_flag;
        logic       comp_init;
        logic       comp_round;
        logic       comp_fold;
        logic [1:0] out_sel;
        logic       clear;
    } shamh_cmd_t;

    typedef struct packed {
        logic in_last;
        logic in_full;
        logic in_ovf;
        logic flag;
        logic fill_14;
        logic fill_15;
        logic round_last;
        logic word_last;
        logic out_free;
    } shamh_stat_t;

endpackage

>>> rtl/shamh_ctrl.sv
module shamh_ctrl
    import shamh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  shamh_stat_t stat,
    output shamh_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MARK = 3'd1;
    localparam logic [2:0] ST_PAD  = 3'd2;
    localparam logic [2:0] ST_LLO  = 3'd3;
    localparam logic [2:0] ST_COMP = 3'd4;
    localparam logic [2:0] ST_FOLD = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;
    localparam logic [2:0] ST_ERR  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [2:0] ret_reg, ret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (stat.flag) begin
                        if (stat.in_last) state_next = ST_ERR;
                    end else if (stat.in_ovf) begin
                        cmd.set_flag = 1'b1;
                        if (stat.in_last) state_next = ST_ERR;
                    end else begin
                        cmd.count_add = 1'b1;
                        if (stat.in_full) cmd.shift_sel = SH_DATA;
                        if (stat.in_full && stat.fill_15) begin
                            cmd.comp_init = 1'b1;
                            ret_next      = stat.in_last ? ST_MARK : ST_IDLE;
                            state_next    = ST_COMP;
                        end else if (stat.in_last) begin
                            state_next = ST_MARK;
                        end
                    end
                end
            end
            ST_MARK: begin
                cmd.shift_sel = SH_MARK;
                if (stat.fill_15) begin
                    cmd.comp_init = 1'b1;
                    ret_next      = ST_PAD;
                    state_next    = ST_COMP;
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                if (stat.fill_14) begin
                    cmd.shift_sel = SH_LHI;
                    state_next    = ST_LLO;
                end else begin
                    cmd.shift_sel = SH_ZERO;
                    if (stat.fill_15) begin
                        cmd.comp_init = 1'b1;
                        ret_next      = ST_PAD;
                        state_next    = ST_COMP;
                    end
                end
            end
            ST_LLO: begin
                cmd.shift_sel = SH_LLO;
                cmd.comp_init = 1'b1;
                ret_next      = ST_OUT;
                state_next    = ST_COMP;
            end
            ST_COMP: begin
                cmd.comp_round = 1'b1;
                if (stat.round_last) state_next = ST_FOLD;
            end
            ST_FOLD: begin
                cmd.comp_fold = 1'b1;
                state_next    = ret_reg;
            end
            ST_OUT: begin
                if (stat.out_free) begin
                    cmd.out_sel = OUT_DIGEST;
                    if (stat.word_last) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ERR: begin
                if (stat.out_free) begin
                    cmd.out_sel = OUT_ERROR;
                    cmd.clear   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/shamh_dp.sv
module shamh_dp
    import shamh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  shamh_cmd_t  cmd,
    output shamh_stat_t stat,
    input  logic [31:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

    logic [31:0]         h_reg [8];
    logic [31:0]         v_reg [8];
    logic [31:0]         w_reg [16];
    logic [3:0]          fill_reg;
    logic [LEN_BITS-1:0] count_reg;
    logic                flag_reg;
    logic [5:0]          rnd_reg;
    logic [2:0]          widx_reg;
    logic [31:0]         ldata_reg;
    logic [2:0]          ln_reg;

    logic                m_valid_reg;
    logic [31:0]         m_data_reg;
    logic [2:0]          m_num_reg;
    logic                m_last_reg;
    logic                m_long_reg;

    logic [2:0]          item_n;
    logic [LEN_BITS:0]   count_sum;
    logic [63:0]         bit_len;
    logic [31:0]         marker;
    logic [31:0]         shift_word;
    logic [31:0]         sched_word;
    logic [31:0]         w_in;
    logic                w_push;
    logic [31:0]         t1, t2;
    logic [31:0]         s0, s1;

    always_comb begin
        if (!s_axis_tlast) item_n = 3'd4;
        else if (s_axis_tuser > 3'd4) item_n = 3'd4;
        else item_n = s_axis_tuser;
        count_sum = {1'b0, count_reg} + (LEN_BITS + 1)'(item_n);
        bit_len   = 64'(count_reg) << 3;

        case (ln_reg)
            3'd1: marker = {ldata_reg[31:24], PAD_MARK, 16'h0000};
            3'd2: marker = {ldata_reg[31:16], PAD_MARK, 8'h00};
            3'd3: marker = {ldata_reg[31:8], PAD_MARK};
            default: marker = {PAD_MARK, 24'h000000};
        endcase

        case (cmd.shift_sel)
            SH_DATA: shift_word = s_axis_tdata;
            SH_MARK: shift_word = marker;
            SH_LHI:  shift_word = bit_len[63:32];
            SH_LLO:  shift_word = bit_len[31:0];
            default: shift_word = 32'h0;
        endcase

        s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        sched_word = w_reg[0] + s0 + w_reg[9] + s1;
        w_push = cmd.comp_round || (cmd.shift_sel != SH_NONE);
        w_in   = cmd.comp_round ? sched_word : shift_word;

        t1 = v_reg[7] + (ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25))
             + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + ROUND_K[rnd_reg] + w_reg[0];
        t2 = (ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22))
             + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign stat.in_last    = s_axis_tlast;
    assign stat.in_full    = (item_n == 3'd4);
    assign stat.in_ovf     = count_sum[LEN_BITS];
    assign stat.flag       = flag_reg;
    assign stat.fill_14    = (fill_reg == 4'd14);
    assign stat.fill_15    = (fill_reg == 4'd15);
    assign stat.round_last = (rnd_reg == 6'd63);
    assign stat.word_last  = (widx_reg == 3'd7);
    assign stat.out_free   = !m_valid_reg || m_axis_tready;

    // message schedule / block buffer and working variables
    always_ff @(posedge aclk) begin
        if (w_push) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_in;
        end
        if (cmd.comp_init) begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
        end else if (cmd.comp_round) begin
            for (int i = 1; i < 8; i++) v_reg[i] <= v_reg[i - 1];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[0] <= t1 + t2;
        end
        if (cmd.count_add) begin
            ldata_reg <= s_axis_tdata;
            ln_reg    <= item_n;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= HASH_IV[i];
            fill_reg  <= '0;
            count_reg <= '0;
            flag_reg  <= 1'b0;
            rnd_reg   <= '0;
            widx_reg  <= '0;
        end else begin
            if (cmd.clear) begin
                for (int i = 0; i < 8; i++) h_reg[i] <= HASH_IV[i];
                fill_reg  <= '0;
                count_reg <= '0;
                flag_reg  <= 1'b0;
                widx_reg  <= '0;
            end else begin
                if (cmd.comp_fold) begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                end
                if (cmd.shift_sel != SH_NONE) fill_reg <= fill_reg + 4'd1;
                if (cmd.count_add) count_reg <= count_sum[LEN_BITS-1:0];
                if (cmd.set_flag) flag_reg <= 1'b1;
                if (cmd.out_sel == OUT_DIGEST) widx_reg <= widx_reg + 3'd1;
            end
            if (cmd.comp_init) rnd_reg <= '0;
            else if (cmd.comp_round) rnd_reg <= rnd_reg + 6'd1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_sel != OUT_NONE) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.out_sel)
            OUT_DIGEST: begin
                m_data_reg <= h_reg[widx_reg];
                m_num_reg  <= widx_reg;
                m_last_reg <= (widx_reg == 3'd7);
                m_long_reg <= 1'b0;
            end
            OUT_ERROR: begin
                m_data_reg <= 32'h0;
                m_num_reg  <= 3'd0;
                m_last_reg <= 1'b1;
                m_long_reg <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = {m_long_reg, m_num_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

>>> rtl/sha256_message_hasher_top.sv
// SHA-256 over a stream of big-endian 32-bit words. A word that completes
// a 64-byte block starts a compression of 64 rounds, one per cycle in the
// round unit, after which the working variables are folded into the hash;
// no new word is taken until that is done. The last word starts padding,
// shifted into the schedule buffer one word per cycle while no compression
// runs (with one or two more compressions), after which eight digest words
// leave at one per cycle while the output is not stalled.
// A message beyond 2^61-1 bytes yields a single result with too_long set.
// Input is taken while the last results still wait in the output register.
module sha256_message_hasher_top
    import shamh_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_word
    input  logic [2:0]  s_axis_tuser,   // valid_bytes
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word
    output logic [3:0]  m_axis_tuser,   // word_number[2:0], too_long[3]
    output logic        m_axis_tlast
);

    shamh_cmd_t  cmd;
    shamh_stat_t stat;

    shamh_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    shamh_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
